[hw/rtl/hbs_pkg.sv]
// shared types, constants and the quarter-wave sine table builder for the harmonic buzz synth
// no dependencies; used by hbs_csr, hbs_ctrl, hbs_datapath and harmonic_buzz_synth
package hbs_pkg;

   // sizing
   localparam int SAMPLE_RATE      = 48000;
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int MAX_CHUNK        = 64;

   localparam int SINE_ADDR_W = $clog2(SINE_TABLE_DEPTH);
   localparam int SINE_IDX_W  = SINE_ADDR_W + 1;
   localparam int CNT_W       = $clog2(MAX_CHUNK + 1);
   localparam int CHUNK_W     = 7;
   localparam int PROD_W      = 62;

   // phase steps and offsets, fractions of a turn times 2^32
   localparam logic [31:0] TREM_STEP =
      32'(((64'd47 << 32) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE));
   localparam logic [31:0] OFFSET_H2 = 32'd410139166;
   localparam logic [31:0] OFFSET_H3 = 32'd956991386;

   // Q0.15 weights
   localparam logic [14:0] W_FUND     = 15'd17039;
   localparam logic [14:0] W_H2       = 15'd9830;
   localparam logic [14:0] W_H3       = 15'd4260;
   localparam logic [14:0] TREM_DEPTH = 15'd5898;
   localparam logic signed [31:0] TREM_BASE_Q30 = 32'sd880476160;  // 26870 * 32768

   localparam logic [15:0] FULL_SCALE = 16'd32768;
   localparam logic [14:0] PCM_MAX    = 15'd32767;

   // register reset values
   localparam logic [31:0] FREQ_STEP_RESET = 32'd53687091;
   localparam logic [15:0] AMPLITUDE_RESET = 16'd32768;

   // register indexes
   typedef enum logic [7:0] {
      CSR_FREQ_STEP = 8'd0,
      CSR_AMPLITUDE = 8'd1
   } csr_index_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADVANCE,
      ST_SINE,
      ST_MUL_TREM,
      ST_MUL_AMP,
      ST_MUL_PCM,
      ST_EMIT
   } state_type;

   // which sine is being looked up
   typedef enum logic [1:0] {
      SEL_FUND,
      SEL_H2,
      SEL_H3,
      SEL_TREM
   } sine_sel_type;

   typedef struct packed {
      logic [31:0] freq_step;
      logic [15:0] amplitude;
   } cfg_type;

   typedef struct packed {
      logic         advance;
      logic         rd_en;
      sine_sel_type rd_sel;
      logic         acc_en;
      logic         mul_trem;
      logic         mul_amp;
      logic         mul_pcm;
      logic         emit;
      logic         last;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

   typedef logic [14:0] sine_rom_type [0:SINE_TABLE_DEPTH];

   // polynomial coefficients, Q30
   localparam logic [63:0] POLY_A = 64'd1686629713;
   localparam logic [63:0] POLY_B = 64'd693598668;
   localparam logic [63:0] POLY_C = 64'd85569306;
   localparam logic [63:0] POLY_D = 64'd5026995;
   localparam logic [63:0] POLY_E = 64'd172272;

   // one quarter-wave entry, Q30 horner form with truncated products
   function automatic logic [14:0] quarter_entry(input int unsigned k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] e;
      x  = (64'(k) << 30) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      p  = POLY_E;
      p  = POLY_D - ((x2 * p) >> 30);
      p  = POLY_C - ((x2 * p) >> 30);
      p  = POLY_B - ((x2 * p) >> 30);
      p  = POLY_A - ((x2 * p) >> 30);
      s  = (x * p) >> 30;
      e  = (s * 64'd32767 + 64'd536870912) >> 30;
      if (e > 64'd32767) begin
         e = 64'd32767;
      end
      return e[14:0];
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int unsigned k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         rom[k] = quarter_entry(k);
      end
      return rom;
   endfunction

endpackage

[hw/rtl/hbs_csr.sv]
// configuration registers: tuning word and output amplitude
// depends on hbs_pkg
module hbs_csr (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [7:0]      csr_index,
   input  logic [31:0]     csr_wdata,
   output hbs_pkg::cfg_type cfg
);

   logic [31:0] freq_step_ff;
   logic [15:0] amplitude_ff;

   assign csr_ready = 1'b1;

   // register writes, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         freq_step_ff <= hbs_pkg::FREQ_STEP_RESET;
         amplitude_ff <= hbs_pkg::AMPLITUDE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hbs_pkg::CSR_FREQ_STEP: freq_step_ff <= csr_wdata;
            hbs_pkg::CSR_AMPLITUDE: amplitude_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign cfg.freq_step = freq_step_ff;
   assign cfg.amplitude = amplitude_ff;

endmodule

[hw/rtl/hbs_ctrl.sv]
// sequencer: takes a request, then steps the datapath through each sample of the chunk
// depends on hbs_pkg
module hbs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [6:0]            req_chunk_length,
   output hbs_pkg::dp_cmd_type   cmd,
   input  hbs_pkg::dp_status_type status
);

   hbs_pkg::state_type state_ff, state_in;
   logic [hbs_pkg::CNT_W-1:0] remaining_ff, remaining_in;
   logic [2:0] step_ff, step_in;
   logic [hbs_pkg::CNT_W-1:0] chunk_sat;
   logic req_take;

   // oversized chunks clip to the maximum
   assign chunk_sat = (req_chunk_length > hbs_pkg::CHUNK_W'(hbs_pkg::MAX_CHUNK))
                    ? hbs_pkg::CNT_W'(hbs_pkg::MAX_CHUNK)
                    : req_chunk_length[hbs_pkg::CNT_W-1:0];
   assign req_stall = (state_ff != hbs_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in     = state_ff;
      remaining_in = remaining_ff;
      step_in      = step_ff;
      unique case (state_ff)
         hbs_pkg::ST_IDLE: begin
            if (req_take && (chunk_sat != '0)) begin
               remaining_in = chunk_sat;
               state_in     = hbs_pkg::ST_ADVANCE;
            end
         end
         hbs_pkg::ST_ADVANCE: begin
            step_in  = '0;
            state_in = hbs_pkg::ST_SINE;
         end
         hbs_pkg::ST_SINE: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd4) begin
               state_in = hbs_pkg::ST_MUL_TREM;
            end
         end
         hbs_pkg::ST_MUL_TREM: state_in = hbs_pkg::ST_MUL_AMP;
         hbs_pkg::ST_MUL_AMP:  state_in = hbs_pkg::ST_MUL_PCM;
         hbs_pkg::ST_MUL_PCM:  state_in = hbs_pkg::ST_EMIT;
         hbs_pkg::ST_EMIT: begin
            if (status.out_free) begin
               remaining_in = remaining_ff - hbs_pkg::CNT_W'(1);
               state_in = (remaining_ff == hbs_pkg::CNT_W'(1))
                        ? hbs_pkg::ST_IDLE : hbs_pkg::ST_ADVANCE;
            end
         end
         default: state_in = hbs_pkg::ST_IDLE;
      endcase
   end

   // datapath commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         hbs_pkg::ST_IDLE: ;
         hbs_pkg::ST_ADVANCE: cmd.advance = 1'b1;
         hbs_pkg::ST_SINE: begin
            // lookup of sine n overlaps the accumulate of sine n-1
            cmd.rd_en  = (step_ff != 3'd4);
            cmd.rd_sel = hbs_pkg::sine_sel_type'(step_ff[1:0]);
            cmd.acc_en = (step_ff != 3'd0);
         end
         hbs_pkg::ST_MUL_TREM: cmd.mul_trem = 1'b1;
         hbs_pkg::ST_MUL_AMP:  cmd.mul_amp  = 1'b1;
         hbs_pkg::ST_MUL_PCM:  cmd.mul_pcm  = 1'b1;
         hbs_pkg::ST_EMIT: begin
            cmd.emit = status.out_free;
            cmd.last = (remaining_ff == hbs_pkg::CNT_W'(1));
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hbs_pkg::ST_IDLE;
         remaining_ff <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         remaining_ff <= remaining_in;
         step_ff      <= step_in;
      end
   end

endmodule

[hw/rtl/hbs_datapath.sv]
// phase accumulators, sine table, weighted sum, gain multiplies and the result register
// depends on hbs_pkg
module hbs_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  hbs_pkg::cfg_type       cfg,
   input  hbs_pkg::dp_cmd_type    cmd,
   output hbs_pkg::dp_status_type status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [15:0]     rsp_sample_value,
   output logic                   rsp_last_in_chunk,
   output logic [47:0]            rsp_total_samples
);

   localparam hbs_pkg::sine_rom_type SINE_ROM = hbs_pkg::build_sine_rom();

   logic [31:0] main_phase_ff;
   logic [31:0] trem_phase_ff;
   logic [47:0] sample_counter_ff;
   logic [14:0] rom_q_ff;
   logic        rom_neg_ff;
   hbs_pkg::sine_sel_type rom_sel_ff;
   logic signed [31:0] acc_ff;
   logic signed [31:0] trem_ff;
   logic        neg_ff;
   logic [hbs_pkg::PROD_W-1:0] prod_ff;
   logic        rsp_valid_ff;
   logic signed [15:0] rsp_sample_ff;
   logic        rsp_last_ff;

   logic [31:0] ph_h2;
   logic [31:0] ph_h3;
   logic [31:0] rd_phase;
   logic [hbs_pkg::SINE_ADDR_W-1:0] rd_k;
   logic [hbs_pkg::SINE_IDX_W-1:0]  rd_idx;
   logic signed [15:0] term;
   logic [14:0] weight;
   logic signed [31:0] mac_prod;
   logic [30:0] acc_mag;
   logic [15:0] amp_sat;
   logic [hbs_pkg::PROD_W-1:0] rnd30;
   logic [hbs_pkg::PROD_W-1:0] rnd15;
   logic [30:0] mul_a;
   logic [30:0] mul_b;
   logic [31:0] pcm_mag;
   logic [14:0] pcm_sat;

   // harmonic phases, modulo one turn
   assign ph_h2 = {main_phase_ff[30:0], 1'b0} + hbs_pkg::OFFSET_H2;
   assign ph_h3 = main_phase_ff + {main_phase_ff[30:0], 1'b0} + hbs_pkg::OFFSET_H3;

   always_comb begin
      case (cmd.rd_sel)
         hbs_pkg::SEL_FUND: rd_phase = main_phase_ff;
         hbs_pkg::SEL_H2:   rd_phase = ph_h2;
         hbs_pkg::SEL_H3:   rd_phase = ph_h3;
         default:           rd_phase = trem_phase_ff;
      endcase
   end

   // quadrant folding into the quarter-wave table
   assign rd_k   = rd_phase[29 -: hbs_pkg::SINE_ADDR_W];
   assign rd_idx = rd_phase[30]
                 ? hbs_pkg::SINE_IDX_W'(hbs_pkg::SINE_TABLE_DEPTH) - {1'b0, rd_k}
                 : {1'b0, rd_k};

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rom_q_ff   <= SINE_ROM[rd_idx];
         rom_neg_ff <= rd_phase[31];
         rom_sel_ff <= cmd.rd_sel;
      end
   end

   // weighted term of the looked-up sine
   assign term = rom_neg_ff ? -$signed({1'b0, rom_q_ff}) : $signed({1'b0, rom_q_ff});

   always_comb begin
      case (rom_sel_ff)
         hbs_pkg::SEL_FUND: weight = hbs_pkg::W_FUND;
         hbs_pkg::SEL_H2:   weight = hbs_pkg::W_H2;
         hbs_pkg::SEL_H3:   weight = hbs_pkg::W_H3;
         default:           weight = hbs_pkg::TREM_DEPTH;
      endcase
   end

   assign mac_prod = 32'(term * $signed({1'b0, weight}));

   // body sum and tremolo gain, both Q30
   always_ff @(posedge clock) begin
      if (cmd.advance) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         if (rom_sel_ff == hbs_pkg::SEL_TREM) begin
            trem_ff <= hbs_pkg::TREM_BASE_Q30 + mac_prod;
         end else begin
            acc_ff <= acc_ff + mac_prod;
         end
      end
   end

   // gain chain on the magnitude; the tremolo gain is always positive
   assign acc_mag = acc_ff[31] ? 31'(-acc_ff) : acc_ff[30:0];
   assign amp_sat = (cfg.amplitude > hbs_pkg::FULL_SCALE) ? hbs_pkg::FULL_SCALE
                                                            : cfg.amplitude;
   assign rnd30 = prod_ff + hbs_pkg::PROD_W'(64'd1 << 29);
   assign rnd15 = prod_ff + hbs_pkg::PROD_W'(64'd1 << 14);

   always_comb begin
      mul_a = acc_mag;
      mul_b = trem_ff[30:0];
      if (cmd.mul_amp) begin
         mul_a = rnd30[60:30];
         mul_b = 31'(amp_sat);
      end else if (cmd.mul_pcm) begin
         mul_a = rnd15[45:15];
         mul_b = 31'(hbs_pkg::PCM_MAX);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_trem || cmd.mul_amp || cmd.mul_pcm) begin
         prod_ff <= hbs_pkg::PROD_W'(mul_a) * hbs_pkg::PROD_W'(mul_b);
      end
      if (cmd.mul_trem) begin
         neg_ff <= acc_ff[31];
      end
   end

   // truncate to pcm scale and clip
   assign pcm_mag = prod_ff[61:30];
   assign pcm_sat = (pcm_mag > 32'(hbs_pkg::PCM_MAX)) ? hbs_pkg::PCM_MAX : pcm_mag[14:0];

   // phase accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         main_phase_ff <= '0;
         trem_phase_ff <= '0;
      end else if (cmd.advance) begin
         main_phase_ff <= main_phase_ff + cfg.freq_step;
         trem_phase_ff <= trem_phase_ff + hbs_pkg::TREM_STEP;
      end
   end

   // result register and running count
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff      <= 1'b0;
         sample_counter_ff <= '0;
      end else if (cmd.emit) begin
         rsp_valid_ff      <= 1'b1;
         sample_counter_ff <= sample_counter_ff + 48'd1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_sample_ff <= neg_ff ? -$signed({1'b0, pcm_sat}) : $signed({1'b0, pcm_sat});
         rsp_last_ff   <= cmd.last;
      end
   end

   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_value  = rsp_sample_ff;
   assign rsp_last_in_chunk = rsp_last_ff;
   assign rsp_total_samples = sample_counter_ff;

endmodule

[hw/rtl/harmonic_buzz_synth.sv]
// harmonic buzz synth: one request gives up to 64 samples, one result per sample
// each sample steps through phase advance, lookups in the single-port sine table with
// overlapped accumulate, 3 passes through the shared gain multiplier, and the output load,
// which waits while the output stalls; a new request is taken once the last sample
// is loaded; zero-length requests are accepted and leave the block idle
// synchronous reset clears phases, sample count and control; registers return to defaults
module harmonic_buzz_synth (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [6:0]         req_chunk_length,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample_value,
   output logic               rsp_last_in_chunk,
   output logic [47:0]        rsp_total_samples,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   hbs_pkg::cfg_type       cfg;
   hbs_pkg::dp_cmd_type    cmd;
   hbs_pkg::dp_status_type status;

   // configuration registers
   hbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer
   hbs_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_chunk_length (req_chunk_length),
      .cmd              (cmd),
      .status           (status)
   );

   // arithmetic and result register
   hbs_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sample_value  (rsp_sample_value),
      .rsp_last_in_chunk (rsp_last_in_chunk),
      .rsp_total_samples (rsp_total_samples)
   );

`ifndef SYNTHESIS
   // clipping keeps samples symmetric
   a_no_min_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample_value != 16'sh8000))
      else $error("sample below -32767");

   // an empty request leaves the block ready
   a_zero_chunk_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_chunk_length == 7'd0)) |=> !req_stall)
      else $error("zero-length request left the block busy");

   // the running count moves only together with a presented sample
   a_count_with_result: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (rsp_total_samples != $past(rsp_total_samples))) |-> rsp_valid)
      else $error("sample count changed without a result");
`endif

endmodule
